// ----- src/sfn_pkg.sv -----
package sfn_pkg;

  // fixed field widths
  localparam int DEN_BITS       = 9;
  localparam int DEN_MAG_BITS   = 8;
  localparam int DEN_SQ_BITS    = 16;
  localparam int COEFF_OUT_BITS = 24;
  localparam int RAD_OUT_BITS   = 16;
  localparam int DEN_OUT_BITS   = 8;

  // the one nonzero denominator code whose magnitude does not fit the output
  localparam logic [DEN_BITS-1:0] DEN_UNREPRESENTABLE = 9'h100;

  // sequencer states
  typedef enum logic [13:0] {
    ST_IDLE      = 14'b00000000000001,
    ST_CHECK     = 14'b00000000000010,
    ST_DIVD_WAIT = 14'b00000000000100,
    ST_ROOT      = 14'b00000000001000,
    ST_KSQ       = 14'b00000000010000,
    ST_KCMP      = 14'b00000000100000,
    ST_FDIV_WAIT = 14'b00000001000000,
    ST_SCALE     = 14'b00000010000000,
    ST_GCD       = 14'b00000100000000,
    ST_GCD_WAIT  = 14'b00001000000000,
    ST_QMAG      = 14'b00010000000000,
    ST_QMAG_WAIT = 14'b00100000000000,
    ST_QDEN_WAIT = 14'b01000000000000,
    ST_DONE      = 14'b10000000000000
  } state_e;

endpackage

// ----- src/sfn_div.sv -----
module sfn_div #(
  parameter int WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int CntW = $clog2(WIDTH);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, quo_q, dvs_q;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_n;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[WIDTH-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_n   = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  end

  // step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[WIDTH-2:0], ge};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- src/surd_fraction_normalizer_top.sv -----
// channel  | valid / ready            | payload
// ---------+--------------------------+------------------------------------------------
// input    | in_valid_i / in_ready_o  | coefficient_i, radicand_i, denominator_i
// output   | out_valid_o / out_ready_i| coefficient_out_o, radicand_out_o,
//          |                          | denominator_out_o, error_o
//
// One transaction at a time; in_ready_o is high only while the sequencer is idle.
// Every divide runs through one shared restoring divider of DW bits (DW = max of
// COEFF_BITS + ceil(RADICAND_BITS/2), RADICAND_BITS, 16). Square-factor trial
// tries divisor 2, then odd values up to sqrt of the radicand, removing each square
// factor found; gcd and the two final divides follow. An error transaction skips
// the divider. A finished result waits in the output register while the next
// transaction is taken. Reset clears the sequencer and output valid.
module surd_fraction_normalizer_top #(
  parameter int COEFF_BITS    = 16,
  parameter int RADICAND_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [COEFF_BITS-1:0]             coefficient_i,
  input  logic        [RADICAND_BITS-1:0]          radicand_i,
  input  logic signed [sfn_pkg::DEN_BITS-1:0]      denominator_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [sfn_pkg::COEFF_OUT_BITS-1:0] coefficient_out_o,
  output logic        [sfn_pkg::RAD_OUT_BITS-1:0]   radicand_out_o,
  output logic        [sfn_pkg::DEN_OUT_BITS-1:0]   denominator_out_o,
  output logic                                     error_o
);

  import sfn_pkg::*;

  localparam int SqW  = (RADICAND_BITS + 1) / 2;
  localparam int KW   = SqW + 1;
  localparam int KsqW = 2 * KW;
  localparam int MW   = COEFF_BITS + SqW;
  localparam int DW0  = (MW > RADICAND_BITS) ? MW : RADICAND_BITS;
  localparam int DW   = (DW0 > DEN_SQ_BITS) ? DW0 : DEN_SQ_BITS;
  localparam int OW   = (MW + 1 > COEFF_OUT_BITS) ? MW + 1 : COEFF_OUT_BITS;
  localparam int RXW  = (RADICAND_BITS > RAD_OUT_BITS) ? RADICAND_BITS : RAD_OUT_BITS;

  state_e state_q, state_d;

  logic signed [COEFF_BITS-1:0] c_q;
  logic [RADICAND_BITS-1:0]     r_q;
  logic [DEN_BITS-1:0]          d_q;
  logic                         err_q;
  logic [COEFF_BITS-1:0]        cmag_q;
  logic                         neg_q;
  logic [DEN_MAG_BITS-1:0]      dmag_q;
  logic [KW-1:0]                k_q;
  logic [KsqW-1:0]              ksq_q;
  logic [SqW-1:0]               sq_q;
  logic [MW-1:0]                mag_q;
  logic [DW-1:0]                ga_q;
  logic [DEN_MAG_BITS-1:0]      gb_q;

  logic                         out_valid_q;
  logic [COEFF_OUT_BITS-1:0]    coef_q;
  logic [RAD_OUT_BITS-1:0]      rad_q;
  logic [DEN_OUT_BITS-1:0]      den_q;
  logic                         err_out_q;

  // shared divider
  logic          div_start;
  logic [DW-1:0] div_a, div_b;
  logic          div_done;
  logic [DW-1:0] div_quo, div_rem;

  // small helpers around the divider
  logic [COEFF_BITS-1:0]     cneg_c, cmag_c;
  logic [DEN_BITS-1:0]       dneg_c;
  logic [DEN_MAG_BITS-1:0]   dmag_c;
  logic [DEN_SQ_BITS-1:0]    dd_c;
  logic [KsqW-1:0]           ksq_c;
  logic [SqW+KW-1:0]         sqk_c;
  logic [MW-1:0]             prod_c;
  logic                      trial_fits;
  logic                      load_out;
  logic [OW-1:0]             mag_ext, cval_c;
  logic [RXW-1:0]            r_ext;

  // magnitudes, squares and products
  always_comb begin
    cneg_c     = ~c_q + COEFF_BITS'(1);
    cmag_c     = c_q[COEFF_BITS-1] ? cneg_c : c_q;
    dneg_c     = ~d_q + DEN_BITS'(1);
    dmag_c     = d_q[DEN_BITS-1] ? dneg_c[DEN_MAG_BITS-1:0] : d_q[DEN_MAG_BITS-1:0];
    dd_c       = DEN_SQ_BITS'(dmag_c) * DEN_SQ_BITS'(dmag_c);
    ksq_c      = KsqW'(k_q) * KsqW'(k_q);
    sqk_c      = (SqW + KW)'(sq_q) * (SqW + KW)'(k_q);
    prod_c     = MW'(cmag_q) * MW'(sq_q);
    trial_fits = ksq_q <= KsqW'(r_q);
  end

  // sequencer and divider operand select
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (err_q) begin
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_a     = DW'(r_q);
          div_b     = DW'(dd_c);
          state_d   = ST_DIVD_WAIT;
        end
      end
      ST_DIVD_WAIT: begin
        if (div_done) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (cmag_q == '0 || r_q == '0) state_d = ST_SCALE;
        else state_d = ST_KSQ;
      end
      ST_KSQ: begin
        state_d = ST_KCMP;
      end
      ST_KCMP: begin
        if (trial_fits) begin
          div_start = 1'b1;
          div_a     = DW'(r_q);
          div_b     = DW'(ksq_q);
          state_d   = ST_FDIV_WAIT;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_FDIV_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) state_d = ST_KCMP;
          else state_d = ST_KSQ;
        end
      end
      ST_SCALE: begin
        state_d = ST_GCD;
      end
      ST_GCD: begin
        if (gb_q == '0) begin
          state_d = ST_QMAG;
        end else begin
          div_start = 1'b1;
          div_a     = ga_q;
          div_b     = DW'(gb_q);
          state_d   = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_done) state_d = ST_GCD;
      end
      ST_QMAG: begin
        div_start = 1'b1;
        div_a     = DW'(mag_q);
        div_b     = ga_q;
        state_d   = ST_QMAG_WAIT;
      end
      ST_QMAG_WAIT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = DW'(dmag_q);
          div_b     = ga_q;
          state_d   = ST_QDEN_WAIT;
        end
      end
      ST_QDEN_WAIT: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c_q   <= coefficient_i;
          r_q   <= radicand_i;
          d_q   <= denominator_i;
          err_q <= (denominator_i == '0) || (denominator_i == DEN_UNREPRESENTABLE);
        end
      end
      ST_CHECK: begin
        cmag_q <= cmag_c;
        neg_q  <= c_q[COEFF_BITS-1] ^ d_q[DEN_BITS-1];
        dmag_q <= dmag_c;
      end
      // denominator squared divides the radicand
      ST_DIVD_WAIT: begin
        if (div_done && div_rem == '0) begin
          r_q    <= div_quo[RADICAND_BITS-1:0];
          dmag_q <= DEN_MAG_BITS'(1);
        end
      end
      ST_ROOT: begin
        if (cmag_q == '0 || r_q == '0) begin
          r_q  <= RADICAND_BITS'(1);
          sq_q <= '0;
        end else begin
          k_q  <= KW'(2);
          sq_q <= SqW'(1);
        end
      end
      ST_KSQ: begin
        ksq_q <= ksq_c;
      end
      // pull a square factor out, or move on to the next trial divisor
      ST_FDIV_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            r_q  <= div_quo[RADICAND_BITS-1:0];
            sq_q <= sqk_c[SqW-1:0];
          end else if (k_q == KW'(2)) begin
            k_q <= KW'(3);
          end else begin
            k_q <= k_q + KW'(2);
          end
        end
      end
      ST_SCALE: begin
        mag_q <= prod_c;
        ga_q  <= DW'(prod_c);
        gb_q  <= dmag_q;
      end
      ST_GCD_WAIT: begin
        if (div_done) begin
          ga_q <= DW'(gb_q);
          gb_q <= div_rem[DEN_MAG_BITS-1:0];
        end
      end
      ST_QMAG_WAIT: begin
        if (div_done) mag_q <= div_quo[MW-1:0];
      end
      ST_QDEN_WAIT: begin
        if (div_done) dmag_q <= div_quo[DEN_MAG_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // result formatting
  always_comb begin
    mag_ext = OW'(mag_q);
    cval_c  = neg_q ? (~mag_ext + OW'(1)) : mag_ext;
    r_ext   = RXW'(r_q);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (err_q) begin
        coef_q    <= '0;
        rad_q     <= '0;
        den_q     <= '0;
        err_out_q <= 1'b1;
      end else begin
        coef_q    <= cval_c[COEFF_OUT_BITS-1:0];
        rad_q     <= r_ext[RAD_OUT_BITS-1:0];
        den_q     <= dmag_q;
        err_out_q <= 1'b0;
      end
    end
  end

  sfn_div #(
    .WIDTH(DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o       = out_valid_q;
  assign coefficient_out_o = coef_q;
  assign radicand_out_o    = rad_q;
  assign denominator_out_o = den_q;
  assign error_o           = err_out_q;

endmodule

// ----- src/sfn_checker.sv -----
module sfn_checker #(
  parameter int COEFF_BITS    = 16,
  parameter int RADICAND_BITS = 16
) (
  input logic                                      clk_i,
  input logic                                      rst_ni,
  input logic                                      in_valid_i,
  input logic                                      in_ready_o,
  input logic signed [COEFF_BITS-1:0]              coefficient_i,
  input logic        [RADICAND_BITS-1:0]           radicand_i,
  input logic signed [sfn_pkg::DEN_BITS-1:0]       denominator_i,
  input logic                                      out_valid_o,
  input logic                                      out_ready_i,
  input logic signed [sfn_pkg::COEFF_OUT_BITS-1:0] coefficient_out_o,
  input logic        [sfn_pkg::RAD_OUT_BITS-1:0]   radicand_out_o,
  input logic        [sfn_pkg::DEN_OUT_BITS-1:0]   denominator_out_o,
  input logic                                      error_o
);

  // an accepted transaction keeps the block busy for at least the next cycle
  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> !in_ready_o;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("input accepted on consecutive cycles");

  // a waiting input transaction holds its payload
  property p_in_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_ready_o) |=>
        (in_valid_i && $stable(coefficient_i) && $stable(radicand_i) &&
         $stable(denominator_i));
  endproperty
  a_in_hold: assert property (p_in_hold)
    else $error("waiting input changed");

  // an error result carries all-zero fields
  property p_error_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && error_o) |->
        (coefficient_out_o == '0 && radicand_out_o == '0 && denominator_out_o == '0);
  endproperty
  a_error_zero: assert property (p_error_zero)
    else $error("error result with nonzero fields");

  // a good result has a positive denominator and a nonzero radicand
  property p_good_nonzero;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !error_o) |-> (denominator_out_o != '0 && radicand_out_o != '0);
  endproperty
  a_good_nonzero: assert property (p_good_nonzero)
    else $error("good result with zero denominator or radicand");

  // a stalled result holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=>
        (out_valid_o && $stable(coefficient_out_o) && $stable(radicand_out_o) &&
         $stable(denominator_out_o) && $stable(error_o));
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("stalled result changed");

endmodule

bind surd_fraction_normalizer_top sfn_checker #(
  .COEFF_BITS    (COEFF_BITS),
  .RADICAND_BITS (RADICAND_BITS)
) u_sfn_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .coefficient_i     (coefficient_i),
  .radicand_i        (radicand_i),
  .denominator_i     (denominator_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .coefficient_out_o (coefficient_out_o),
  .radicand_out_o    (radicand_out_o),
  .denominator_out_o (denominator_out_o),
  .error_o           (error_o)
);
